/* rtl/core/istr_pkg.sv */
package istr_pkg;

  // Default number of sensor table entries.
  localparam int unsigned MAX_SENSORS_DEF = 15;

  // Entries in the queue between the command front end and the reply sender.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Longest reply body, checksum not counted.
  localparam int unsigned BODY_MAX = 6;

  localparam logic [7:0]  CMD_LENGTH    = 8'd4;
  localparam logic [7:0]  GAP_MS_RESET  = 8'd3;
  localparam logic [7:0]  MS_SATURATED  = 8'hFF;
  localparam logic [15:0] CK_SEED       = 16'hFFFF;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_TABLE = 2'd2
  } req_kind_e;

  typedef enum logic [3:0] {
    CMD_DISCOVER = 4'h8,
    CMD_TYPE     = 4'h9,
    CMD_VALUE    = 4'hA
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_SENSOR_COUNT = 2'd0,
    CFG_GAP_MS       = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SEND = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  rx_byte;
    logic [3:0]  sensor_index;
    logic [7:0]  sensor_kind;
    logic        value_is_wide;
    logic [31:0] sensor_value;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } rsp_t;

  // Reply body as assembled by the front end; the sender appends the checksum.
  typedef struct packed {
    logic [2:0]                   body_len;
    logic [BODY_MAX-1:0][7:0]     body;
  } reply_t;

endpackage

/* rtl/core/ibus_sensor_telemetry_responder_unit.sv */
// Path: a reply is written into the reply queue by the request that completes its command, then
// loaded into the sender's body register and sent through its output register. Throughput: one
// request per cycle while the reply queue has room; one reply byte per cycle from the sender
// while the output is not stalled; a reply is up to eight bytes long. Reset: sensor table and
// partial command cleared, gap counter set to all ones (gap open), sensor_count 0, gap_ms 3.
module ibus_sensor_telemetry_responder_unit #(
  parameter int unsigned MaxSensors = istr_pkg::MAX_SENSORS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  istr_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output istr_pkg::rsp_t out_rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i
);
  import istr_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  reply_t q_in;
  reply_t q_out;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  istr_front #(
    .MaxSensors(MaxSensors)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  istr_queue #(
    .Width($bits(reply_t)),
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_out),
    .pop_i  (q_pop)
  );

  istr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_out),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

`ifndef SYNTH
  // The front end must never hand a reply to a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full))
    else $error("reply pushed into a full queue");

  // Only a received byte can complete a command.
  a_push_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (in_req_i.req_type == REQ_BYTE))
    else $error("reply queued by a non-byte request");

  // After a reply's last byte is taken, the next byte shown opens a new reply.
  a_reply_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_rsp_o.last_byte) |=>
      (!out_valid_o || out_rsp_o.tx_byte == 8'd4 || out_rsp_o.tx_byte == 8'd6 ||
       out_rsp_o.tx_byte == 8'd8))
    else $error("reply does not start with a length byte");
`endif

endmodule

/* rtl/core/istr_front.sv */
module istr_front #(
  parameter int unsigned MaxSensors = istr_pkg::MAX_SENSORS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  istr_pkg::req_t   in_req_i,
  input  logic             cfg_valid_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output istr_pkg::reply_t q_data_o
);
  import istr_pkg::*;

  localparam int unsigned SlotW = (MaxSensors > 1) ? $clog2(MaxSensors) : 1;
  localparam logic [3:0]  MaxId = 4'(MaxSensors);

  logic [3:0]  sensor_count_q;
  logic [7:0]  gap_q;
  logic [7:0]  ms_q;
  logic [7:0]  frame_q [3];
  logic [1:0]  fcount_q;
  logic [7:0]  type_q  [MaxSensors];
  logic        wide_q  [MaxSensors];
  logic [31:0] value_q [MaxSensors];

  logic             accept;
  logic             in_gap;
  logic             cmd_done;
  logic             len_ok;
  logic             ck_ok;
  logic [15:0]      ck_exp;
  logic [3:0]       id;
  logic [3:0]       nib;
  logic [3:0]       limit;
  logic             id_ok;
  logic [SlotW-1:0] rd_slot;
  logic [SlotW-1:0] wr_slot;
  logic             wr_ok;
  logic             known;
  reply_t           reply;
  logic [7:0]       rd_type;
  logic             rd_wide;
  logic [31:0]      rd_value;

  assign accept   = in_valid_i && !q_full_i;
  assign in_gap   = ms_q < gap_q;
  assign cmd_done = accept && (in_req_i.req_type == REQ_BYTE) && !in_gap && (fcount_q == 2'd3);

  assign len_ok = frame_q[0] == CMD_LENGTH;
  assign ck_exp = CK_SEED - {8'h00, frame_q[0]} - {8'h00, frame_q[1]};
  assign ck_ok  = ck_exp == {in_req_i.rx_byte, frame_q[2]};

  assign id    = frame_q[1][3:0];
  assign nib   = frame_q[1][7:4];
  assign limit = (sensor_count_q > MaxId) ? MaxId : sensor_count_q;
  assign id_ok = (id != 4'd0) && (id <= limit);

  assign rd_slot  = SlotW'(id - 4'd1);
  assign rd_type  = type_q[rd_slot];
  assign rd_wide  = wide_q[rd_slot];
  assign rd_value = value_q[rd_slot];

  assign wr_slot = SlotW'(in_req_i.sensor_index - 4'd1);
  assign wr_ok   = (in_req_i.sensor_index != 4'd0) && (in_req_i.sensor_index <= MaxId);

  always_comb begin
    reply         = '0;
    known         = 1'b1;
    reply.body[1] = frame_q[1];
    case (nib)
      CMD_DISCOVER: begin
        reply.body_len = 3'd2;
        reply.body[0]  = 8'd4;
      end
      CMD_TYPE: begin
        reply.body_len = 3'd4;
        reply.body[0]  = 8'd6;
        reply.body[2]  = rd_type;
        reply.body[3]  = rd_wide ? 8'd4 : 8'd2;
      end
      CMD_VALUE: begin
        reply.body_len = rd_wide ? 3'd6 : 3'd4;
        reply.body[0]  = rd_wide ? 8'd8 : 8'd6;
        reply.body[2]  = rd_value[7:0];
        reply.body[3]  = rd_value[15:8];
        reply.body[4]  = rd_value[23:16];
        reply.body[5]  = rd_value[31:24];
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign q_push_o = cmd_done && len_ok && ck_ok && id_ok && known;
  assign q_data_o = reply;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_count_q <= '0;
      gap_q          <= GAP_MS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SENSOR_COUNT: sensor_count_q <= cfg_data_i[3:0];
        CFG_GAP_MS:       gap_q          <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A byte that arrives inside the quiet gap drops any partial command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q     <= MS_SATURATED;
      fcount_q <= '0;
      for (int i = 0; i < 3; i++) begin
        frame_q[i] <= '0;
      end
      for (int i = 0; i < int'(MaxSensors); i++) begin
        type_q[i]  <= '0;
        wide_q[i]  <= 1'b0;
        value_q[i] <= '0;
      end
    end else if (accept) begin
      case (in_req_i.req_type)
        REQ_BYTE: begin
          if (in_gap) begin
            fcount_q <= '0;
          end else if (fcount_q != 2'd3) begin
            frame_q[fcount_q] <= in_req_i.rx_byte;
            fcount_q          <= fcount_q + 2'd1;
          end else begin
            fcount_q <= '0;
            ms_q     <= '0;
          end
        end
        REQ_TICK: begin
          if (ms_q != MS_SATURATED) begin
            ms_q <= ms_q + 8'd1;
          end
        end
        REQ_TABLE: begin
          if (wr_ok) begin
            type_q[wr_slot]  <= in_req_i.sensor_kind;
            wide_q[wr_slot]  <= in_req_i.value_is_wide;
            value_q[wr_slot] <= in_req_i.sensor_value;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/istr_queue.sv */
module istr_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  input  logic             pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/istr_back.sv */
module istr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  istr_pkg::reply_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output istr_pkg::rsp_t   out_rsp_o
);
  import istr_pkg::*;

  back_state_e state_q, state_d;
  reply_t      body_q;
  logic [2:0]  idx_q;
  logic [15:0] ck_q;
  logic        out_valid_q;
  rsp_t        out_q;

  logic       slot_free;
  logic       emit;
  logic       in_body;
  logic       is_last;
  logic [7:0] body_byte;
  logic [7:0] cur_byte;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_body   = idx_q < body_q.body_len;
  assign is_last   = {1'b0, idx_q} == ({1'b0, body_q.body_len} + 4'd1);

  always_comb begin
    case (idx_q)
      3'd0:    body_byte = body_q.body[0];
      3'd1:    body_byte = body_q.body[1];
      3'd2:    body_byte = body_q.body[2];
      3'd3:    body_byte = body_q.body[3];
      3'd4:    body_byte = body_q.body[4];
      3'd5:    body_byte = body_q.body[5];
      default: body_byte = '0;
    endcase
  end

  // Output decode: the checksum low byte follows the body, then the high byte.
  always_comb begin
    emit = (state_q == BK_SEND) && slot_free;
    if (in_body) begin
      cur_byte = body_byte;
    end else if (!is_last) begin
      cur_byte = ck_q[7:0];
    end else begin
      cur_byte = ck_q[15:8];
    end
    q_pop_o = q_valid_i && ((state_q == BK_IDLE) || (emit && is_last));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_pop_o) begin
          state_d = BK_SEND;
        end
      end
      BK_SEND: begin
        if (emit && is_last) begin
          state_d = q_pop_o ? BK_SEND : BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (slot_free) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      body_q <= q_data_i;
      idx_q  <= '0;
      ck_q   <= CK_SEED;
    end else if (emit) begin
      idx_q <= idx_q + 3'd1;
      if (in_body) begin
        ck_q <= ck_q - {8'h00, cur_byte};
      end
    end
    if (emit) begin
      out_q.tx_byte   <= cur_byte;
      out_q.last_byte <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
